FILE: src/word_frequency_hash_counter_top_macros.svh
// Assertion macros shared by the word frequency counter RTL.
`ifndef WORD_FREQUENCY_HASH_COUNTER_TOP_MACROS_SVH
`define WORD_FREQUENCY_HASH_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WFHC_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("wfhc check failed");
`define WFHC_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wfhc check failed");
`else
`define WFHC_ALWAYS(label, cond)
`define WFHC_IMPLY(label, ante, cons)
`endif
`endif

FILE: src/wfhc_pkg.sv
// Types and constants of the word frequency hash counter.
package wfhc_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 32;
    localparam int KEY_W       = 60;
    localparam int UNIQ_W      = 11;
    localparam int WS_W        = 6;
    localparam int ENTRY_W     = KEY_W + COUNT_W;
    localparam logic [WS_W-1:0] WS_MIN   = WS_W'(2);
    localparam logic [WS_W-1:0] WS_MAX   = WS_W'(KEY_W);
    localparam logic [WS_W-1:0] WS_RESET = WS_W'(8);
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_SLOT    = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_OVFL   = 2'd2;
    localparam logic [1:0] ST_HALTED = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   word_value;
        logic [ADDR_W-1:0]  slot;
        logic [COUNT_W-1:0] word_count;
        logic [UNIQ_W-1:0]  unique_words;
        logic [WS_W-1:0]    pad_bits;
        logic [1:0]         status;
        logic               last_result;
    } t_result;
endpackage

FILE: src/wfhc_if.sv
// Handshake channels of the word frequency hash counter.
interface wfhc_in_if import wfhc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [ADDR_W-1:0] slot_select;
    modport source (output valid, operation, data_byte, last_byte, slot_select, input ready);
    modport sink   (input valid, operation, data_byte, last_byte, slot_select, output ready);
endinterface

interface wfhc_out_if import wfhc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [KEY_W-1:0]   word_value;
    logic [ADDR_W-1:0]  slot;
    logic [COUNT_W-1:0] word_count;
    logic [UNIQ_W-1:0]  unique_words;
    logic [WS_W-1:0]    pad_bits;
    logic [1:0]         status;
    logic               last_result;
    modport source (output valid, kind, word_value, slot, word_count, unique_words,
                    pad_bits, status, last_result, input ready);
    modport sink   (input valid, kind, word_value, slot, word_count, unique_words,
                    pad_bits, status, last_result, output ready);
endinterface

FILE: src/wfhc_ram.sv
// Generic single-port-write, registered-read RAM.
module wfhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/word_frequency_hash_counter_top.sv
// Top level: byte slicer, linear-probe sequencer and result queue of the word counter.
//
//  channel    dir  handshake          beat contents
//  i_in_ch    in   valid/ready        operation, data_byte, last_byte, slot_select
//  o_out_ch   out  valid/ready        kind, word_value, slot, word_count, unique_words,
//                                     pad_bits, status, last_result
//  i_cfg_*    in   write enable only  word_size (6 bits)
//
// A data byte with no finished word runs the shift steps for its eight bits, then decide,
// flush and idle before the next accept; each finished word adds a RAM read and then a
// compare per probed slot, and a push. A padded final word costs three probe sequences
// and then the summary. A slot read issues the read, takes the data, pushes and flushes;
// a clear sweeps 1024 slots. After reset the same sweep runs before any beat is taken.
// A push waits while the output register holds an untaken beat.
`include "word_frequency_hash_counter_top_macros.svh"
module word_frequency_hash_counter_top import wfhc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [WS_W-1:0]    i_cfg_data,
    wfhc_in_if.sink            i_in_ch,
    wfhc_out_if.source         o_out_ch
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SHIFT, S_PISSUE, S_PCHECK, S_RDISSUE, S_RDDATA,
        S_SUMMARY, S_PUSH, S_FLUSH
    } t_state;
    typedef enum logic [1:0] {M_LOOKLO, M_LOOKHI, M_COUNT} t_mode;

    t_state              r_state, r_ret, r_cnt_ret;
    t_mode               r_mode;
    logic [WS_W-1:0]     r_word_size, r_fill, r_pad;
    logic [KEY_W-1:0]    r_buf, r_pword, r_lo, r_hi;
    logic [7:0]          r_byte;
    logic [3:0]          r_bits;
    logic                r_last, r_halted, r_clr_emit;
    logic [ADDR_W-1:0]   r_paddr, r_pcnt;
    logic [COUNT_W-1:0]  r_clo;
    logic [UNIQ_W-1:0]   r_distinct;
    t_result             r_new, r_pend, r_out;
    logic                r_pend_valid, r_out_valid;

    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [KEY_W-1:0]    rd_key, shift_buf, lo_word, hi_word;
    logic [COUNT_W-1:0]  rd_count;
    logic [WS_W-1:0]     fill_nx, pad_nx, ws_clamp;
    logic                hit, probe_end, out_free, fresh, at_top, out_load;

    wfhc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_paddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_paddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        rd_key    = ram_rdata[ENTRY_W-1:COUNT_W];
        rd_count  = ram_rdata[COUNT_W-1:0];
        hit       = (rd_count == '0) || (rd_key == r_pword);
        probe_end = (r_pcnt == ADDR_W'(TABLE_DEPTH - 1));
        fresh     = (rd_count == '0);
        at_top    = (rd_count == {COUNT_W{1'b1}});
        shift_buf = {r_buf[KEY_W-2:0], r_byte[7]};
        fill_nx   = r_fill + WS_W'(1);
        pad_nx    = r_word_size - r_fill;
        lo_word   = (r_buf << pad_nx) & ~({KEY_W{1'b1}} << r_word_size);
        hi_word   = lo_word | ~({KEY_W{1'b1}} << pad_nx);
        out_free  = !r_out_valid || o_out_ch.ready;
        out_load  = r_pend_valid && out_free && ((r_state == S_PUSH) || (r_state == S_FLUSH));
        ws_clamp  = (i_cfg_data < WS_MIN) ? WS_MIN :
                    (i_cfg_data > WS_MAX) ? WS_MAX : i_cfg_data;
        ram_we    = 1'b0;
        ram_wdata = {r_pword, rd_count + COUNT_W'(1)};
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end else if (r_state == S_PCHECK && r_mode == M_COUNT && hit && !at_top) begin
            ram_we = 1'b1;
        end
    end

    assign i_in_ch.ready         = (r_state == S_IDLE) && !r_pend_valid;
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.kind         = r_out.kind;
    assign o_out_ch.word_value   = r_out.word_value;
    assign o_out_ch.slot         = r_out.slot;
    assign o_out_ch.word_count   = r_out.word_count;
    assign o_out_ch.unique_words = r_out.unique_words;
    assign o_out_ch.pad_bits     = r_out.pad_bits;
    assign o_out_ch.status       = r_out.status;
    assign o_out_ch.last_result  = r_out.last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_ret        <= S_IDLE;
            r_cnt_ret    <= S_SHIFT;
            r_mode       <= M_COUNT;
            r_word_size  <= WS_RESET;
            r_fill       <= '0;
            r_buf        <= '0;
            r_pad        <= '0;
            r_bits       <= '0;
            r_last       <= 1'b0;
            r_halted     <= 1'b0;
            r_clr_emit   <= 1'b0;
            r_paddr      <= '0;
            r_pcnt       <= '0;
            r_distinct   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_paddr <= r_paddr + ADDR_W'(1);
                    if (r_paddr == ADDR_W'(TABLE_DEPTH - 1)) begin
                        if (r_clr_emit) begin
                            r_new   <= '{KIND_CLEAR, '0, '0, '0, '0, '0, ST_OK, 1'b0};
                            r_ret   <= S_FLUSH;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_in_ch.valid && i_in_ch.ready) begin
                        case (i_in_ch.operation)
                            OP_DATA: begin
                                if (r_halted) begin
                                    r_new   <= '{KIND_WORD, '0, '0, '0, r_distinct, '0,
                                                 ST_HALTED, 1'b0};
                                    r_ret   <= S_FLUSH;
                                    r_state <= S_PUSH;
                                end else begin
                                    r_byte  <= i_in_ch.data_byte & BYTE_MASK;
                                    r_bits  <= 4'd8;
                                    r_last  <= i_in_ch.last_byte;
                                    r_state <= S_SHIFT;
                                end
                            end
                            OP_READ: begin
                                r_paddr <= i_in_ch.slot_select;
                                r_state <= S_RDISSUE;
                            end
                            OP_CLEAR: begin
                                r_paddr    <= '0;
                                r_clr_emit <= 1'b1;
                                r_distinct <= '0;
                                r_buf      <= '0;
                                r_fill     <= '0;
                                r_halted   <= 1'b0;
                                r_state    <= S_CLR;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (r_bits != 4'd0) begin
                        r_byte <= {r_byte[6:0], 1'b0};
                        r_bits <= r_bits - 4'd1;
                        if (fill_nx == r_word_size) begin
                            r_pword   <= shift_buf;
                            r_paddr   <= shift_buf[ADDR_W-1:0];
                            r_pcnt    <= '0;
                            r_buf     <= '0;
                            r_fill    <= '0;
                            r_mode    <= M_COUNT;
                            r_cnt_ret <= S_SHIFT;
                            r_state   <= S_PISSUE;
                        end else begin
                            r_buf  <= shift_buf;
                            r_fill <= fill_nx;
                        end
                    end else if (r_last) begin
                        if (r_fill != '0) begin
                            r_lo      <= lo_word;
                            r_hi      <= hi_word;
                            r_pad     <= pad_nx;
                            r_pword   <= lo_word;
                            r_paddr   <= lo_word[ADDR_W-1:0];
                            r_pcnt    <= '0;
                            r_buf     <= '0;
                            r_fill    <= '0;
                            r_mode    <= M_LOOKLO;
                            r_cnt_ret <= S_SUMMARY;
                            r_state   <= S_PISSUE;
                        end else begin
                            r_pad   <= '0;
                            r_state <= S_SUMMARY;
                        end
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_PISSUE: begin
                    r_state <= S_PCHECK;
                end
                S_PCHECK: begin
                    if (hit || probe_end) begin
                        r_pcnt <= '0;
                        case (r_mode)
                            M_LOOKLO: begin
                                r_clo   <= hit ? rd_count : '0;
                                r_pword <= r_hi;
                                r_paddr <= r_hi[ADDR_W-1:0];
                                r_mode  <= M_LOOKHI;
                                r_state <= S_PISSUE;
                            end
                            M_LOOKHI: begin
                                // ones padding only on a strictly higher count
                                if (hit && rd_count > r_clo) begin
                                    r_pword <= r_hi;
                                    r_paddr <= r_hi[ADDR_W-1:0];
                                end else begin
                                    r_pword <= r_lo;
                                    r_paddr <= r_lo[ADDR_W-1:0];
                                end
                                r_mode  <= M_COUNT;
                                r_state <= S_PISSUE;
                            end
                            default: begin
                                r_state <= S_PUSH;
                                if (!hit) begin
                                    r_halted <= 1'b1;
                                    r_new    <= '{KIND_WORD, r_pword, '0, '0, r_distinct,
                                                  '0, ST_FULL, 1'b0};
                                    r_ret    <= S_FLUSH;
                                end else if (fresh) begin
                                    r_distinct <= r_distinct + UNIQ_W'(1);
                                    r_new      <= '{KIND_WORD, r_pword, r_paddr,
                                                    COUNT_W'(1), r_distinct + UNIQ_W'(1),
                                                    '0, ST_OK, 1'b0};
                                    r_ret      <= r_cnt_ret;
                                end else if (at_top) begin
                                    r_halted <= 1'b1;
                                    r_new    <= '{KIND_WORD, r_pword, r_paddr, rd_count,
                                                  r_distinct, '0, ST_OVFL, 1'b0};
                                    r_ret    <= S_FLUSH;
                                end else begin
                                    r_new <= '{KIND_WORD, r_pword, r_paddr,
                                               rd_count + COUNT_W'(1), r_distinct,
                                               '0, ST_OK, 1'b0};
                                    r_ret <= r_cnt_ret;
                                end
                            end
                        endcase
                    end else begin
                        r_paddr <= r_paddr + ADDR_W'(1);
                        r_pcnt  <= r_pcnt + ADDR_W'(1);
                        r_state <= S_PISSUE;
                    end
                end
                S_RDISSUE: begin
                    r_state <= S_RDDATA;
                end
                S_RDDATA: begin
                    r_new   <= '{KIND_SLOT, fresh ? '0 : rd_key, r_paddr, rd_count,
                                 r_distinct, '0, r_halted ? ST_HALTED : ST_OK, 1'b0};
                    r_ret   <= S_FLUSH;
                    r_state <= S_PUSH;
                end
                S_SUMMARY: begin
                    r_new   <= '{KIND_SUMMARY, '0, '0, '0, r_distinct, r_pad, ST_OK, 1'b0};
                    r_ret   <= S_FLUSH;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // hold the newest result back until we know whether it is the final one
                    if (out_free) begin
                        if (r_pend_valid) begin
                            r_out <= r_pend;
                        end
                        r_pend       <= r_new;
                        r_pend_valid <= 1'b1;
                        r_state      <= r_ret;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out        <= {r_pend[$bits(t_result)-1:1], 1'b1};
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                r_word_size <= ws_clamp;
                r_buf       <= '0;
                r_fill      <= '0;
            end
        end
    end

    `WFHC_IMPLY(a_ready_no_pend, i_in_ch.ready, !r_pend_valid)
    `WFHC_IMPLY(a_sweep_blocks, r_state == S_CLR, !i_in_ch.ready)
    `WFHC_ALWAYS(a_fill_below_size, r_fill < r_word_size)
    `WFHC_ALWAYS(a_distinct_bound, r_distinct <= UNIQ_W'(TABLE_DEPTH))
endmodule

FILE: verif/word_frequency_hash_counter_top_tb.sv
// Testbench of the word frequency hash counter: predicted results checked beat by beat.
`timescale 1ns / 100ps
module word_frequency_hash_counter_top_tb;
    import wfhc_pkg::*;

    // Tracks the table contents and the queue of results the block still owes.
    class word_table_scoreboard;
        bit [KEY_W-1:0]   keys [TABLE_DEPTH];
        bit [COUNT_W-1:0] counts [TABLE_DEPTH];
        bit [66:0]        bits_held;
        int               bits_fill;
        int               distinct;
        bit               halted;
        int               word_bits;
        t_result          owed_results [$];
        int               errors;

        function new();
            foreach (counts[i]) counts[i] = '0;
            bits_held = '0;
            bits_fill = 0;
            distinct = 0;
            halted = 0;
            word_bits = int'(WS_RESET);
            errors = 0;
        endfunction

        function void set_word_size(bit [WS_W-1:0] v);
            word_bits = (v < WS_MIN) ? int'(WS_MIN) : (v > WS_MAX) ? int'(WS_MAX) : int'(v);
            bits_held = '0;
            bits_fill = 0;
        endfunction

        function t_result make(bit [1:0] kind, bit [KEY_W-1:0] w, bit [ADDR_W-1:0] s,
                               bit [COUNT_W-1:0] c, bit [WS_W-1:0] pad, bit [1:0] st);
            t_result r;
            r.kind = kind;
            r.word_value = w;
            r.slot = s;
            r.word_count = c;
            r.unique_words = UNIQ_W'(distinct);
            r.pad_bits = pad;
            r.status = st;
            r.last_result = 1'b0;
            return r;
        endfunction

        // Linear probe from the home slot; stop on a hit or an empty slot.
        function bit find_slot(bit [KEY_W-1:0] w, output int where);
            int s;
            s = int'(w % TABLE_DEPTH);
            where = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (counts[s] == 0 || keys[s] == w) begin
                    where = s;
                    return 1'b1;
                end
                s = (s + 1) % TABLE_DEPTH;
            end
            return 1'b0;
        endfunction

        function bit [COUNT_W-1:0] lookup(bit [KEY_W-1:0] w);
            int s;
            if (!find_slot(w, s)) return '0;
            return counts[s];
        endfunction

        function bit tally_word(bit [KEY_W-1:0] w, ref t_result batch [$]);
            int s;
            if (!find_slot(w, s)) begin
                halted = 1;
                batch.push_back(make(KIND_WORD, w, '0, '0, '0, ST_FULL));
                return 1'b0;
            end
            if (counts[s] == 0) begin
                keys[s] = w;
                counts[s] = 1;
                distinct++;
            end else if (counts[s] == {COUNT_W{1'b1}}) begin
                halted = 1;
                batch.push_back(make(KIND_WORD, w, ADDR_W'(s), counts[s], '0, ST_OVFL));
                return 1'b0;
            end else begin
                counts[s]++;
            end
            batch.push_back(make(KIND_WORD, w, ADDR_W'(s), counts[s], '0, ST_OK));
            return 1'b1;
        endfunction

        function void note_input(bit [1:0] op, bit [7:0] b, bit last, bit [ADDR_W-1:0] sel);
            t_result batch [$];
            bit [KEY_W-1:0] wmask, lo, hi, w;
            int pad;
            bit ok;
            ok = 1'b1;
            wmask = (KEY_W'(1) << word_bits) - 1;
            if (op == OP_READ) begin
                batch.push_back(make(KIND_SLOT, counts[sel] != 0 ? keys[sel] : '0, sel,
                                     counts[sel], '0, halted ? ST_HALTED : ST_OK));
            end else if (op == OP_CLEAR) begin
                foreach (counts[i]) counts[i] = '0;
                distinct = 0;
                bits_held = '0;
                bits_fill = 0;
                halted = 0;
                batch.push_back(make(KIND_CLEAR, '0, '0, '0, '0, ST_OK));
            end else if (op == OP_DATA) begin
                if (halted) begin
                    batch.push_back(make(KIND_WORD, '0, '0, '0, '0, ST_HALTED));
                end else begin
                    for (int i = 7; i >= 0 && ok; i--) begin
                        bits_held = {bits_held[65:0], b[i]};
                        bits_fill++;
                        if (bits_fill >= word_bits) begin
                            w = bits_held[KEY_W-1:0] & wmask;
                            bits_held = '0;
                            bits_fill = 0;
                            ok = tally_word(w, batch);
                        end
                    end
                    if (ok && last) begin
                        pad = 0;
                        if (bits_fill > 0) begin
                            pad = word_bits - bits_fill;
                            lo = (bits_held[KEY_W-1:0] << pad) & wmask;
                            hi = lo | ((KEY_W'(1) << pad) - 1);
                            bits_held = '0;
                            bits_fill = 0;
                            ok = tally_word(lookup(hi) > lookup(lo) ? hi : lo, batch);
                        end
                        if (ok) batch.push_back(make(KIND_SUMMARY, '0, '0, '0, WS_W'(pad), ST_OK));
                    end
                end
            end
            if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
            foreach (batch[i]) owed_results.push_back(batch[i]);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = owed_results.pop_front();
            if (got.kind !== exp.kind || got.word_value !== exp.word_value ||
                got.slot !== exp.slot || got.word_count !== exp.word_count ||
                got.unique_words !== exp.unique_words || got.pad_bits !== exp.pad_bits ||
                got.status !== exp.status || got.last_result !== exp.last_result) begin
                $display("%0t: expected %p", $time, exp);
                $display("%0t: actual   %p", $time, got);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [WS_W-1:0] i_cfg_data;
    wfhc_in_if       in_ch ();
    wfhc_out_if      out_ch ();

    word_table_scoreboard tally_sb;
    bit  quiet;
    int  hold_cycles;
    int  idle_run;

    word_frequency_hash_counter_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result sink: random stalls, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end else begin
            out_ch.ready = quiet ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_result got;
            got.kind = out_ch.kind;
            got.word_value = out_ch.word_value;
            got.slot = out_ch.slot;
            got.word_count = out_ch.word_count;
            got.unique_words = out_ch.unique_words;
            got.pad_bits = out_ch.pad_bits;
            got.status = out_ch.status;
            got.last_result = out_ch.last_result;
            tally_sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("word_frequency_hash_counter_top: mismatch");
                $finish;
            end
        end
    end

    task automatic send_beat(bit [1:0] op, bit [7:0] b, bit last, bit [ADDR_W-1:0] sel);
        if (!quiet && $urandom_range(99) < 32) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.data_byte = b;
        in_ch.last_byte = last;
        in_ch.slot_select = sel;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready) break;
        end
        tally_sb.note_input(op, b, last, sel);
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed result is back and the block settles.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (tally_sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_word_size(bit [WS_W-1:0] v);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tally_sb.set_word_size(v);
    endtask

    function automatic bit [7:0] pick_byte();
        bit [7:0] pool [4] = '{8'h00, 8'hFF, 8'hA5, 8'h0F};
        return ($urandom_range(3) == 0) ? 8'($urandom) : pool[$urandom_range(3)];
    endfunction

    // A stream of bytes ending in a last byte, with some noise and cut streams.
    task automatic random_items(int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: send_beat(OP_READ, 8'($urandom), 1'($urandom), ADDR_W'($urandom));
                    1: send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), ADDR_W'($urandom));
                    2: send_beat(2'd3, 8'($urandom), 1'($urandom), ADDR_W'($urandom));
                    default: send_beat(OP_READ, '0, 1'b0, ADDR_W'($urandom_range(15)));
                endcase
                sent++;
            end else begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++) begin
                    send_beat(OP_DATA, pick_byte(),
                              (i == len - 1) && ($urandom_range(7) != 0), ADDR_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        bit [WS_W-1:0] sizes [6] = '{6'd5, 6'd2, 6'd60, 6'd13, 6'd37, 6'd8};
        tally_sb = new();
        quiet = 1'b0;
        hold_cycles = 0;
        idle_run = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_DATA;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        in_ch.slot_select = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every operation, ignored op, reads and clears.
        send_beat(OP_DATA, 8'h00, 1'b0, '0);
        send_beat(OP_DATA, 8'hFF, 1'b1, '1);
        send_beat(OP_DATA, 8'h00, 1'b1, '0);
        send_beat(OP_READ, 8'hFF, 1'b1, '0);
        send_beat(OP_READ, 8'h00, 1'b0, '1);
        send_beat(OP_READ, 8'h00, 1'b0, ADDR_W'(255));
        send_beat(2'd3, 8'hFF, 1'b1, '1);
        send_beat(OP_DATA, 8'hFF, 1'b1, '0);
        // Partial word left behind, then dropped by the register write.
        write_word_size(6'd5);
        send_beat(OP_DATA, 8'hFF, 1'b0, '0);
        write_word_size(6'd0);
        send_beat(OP_DATA, 8'hFF, 1'b0, '0);
        send_beat(OP_DATA, 8'h1B, 1'b1, '0);
        write_word_size(6'd63);
        send_beat(OP_DATA, 8'hFF, 1'b0, '0);
        send_beat(OP_DATA, 8'h80, 1'b1, '0);
        // Ones padding wins once the all-ones word leads.
        write_word_size(6'd3);
        send_beat(OP_DATA, 8'hFF, 1'b0, '0);
        send_beat(OP_DATA, 8'hFF, 1'b1, '0);
        send_beat(OP_DATA, 8'h00, 1'b1, '0);
        send_beat(OP_CLEAR, 8'h00, 1'b0, '0);
        send_beat(OP_READ, 8'h00, 1'b0, ADDR_W'(7));

        // Colliding words: two long probe chains, one wrapping past the top slot.
        write_word_size(6'd16);
        quiet = 1'b1;
        for (int k = 0; k < 10; k++) begin
            send_beat(OP_DATA, 8'(k << 2), 1'b0, '0);
            send_beat(OP_DATA, 8'h00, 1'b0, '0);
            send_beat(OP_DATA, 8'((k << 2) | 3), 1'b0, '0);
            send_beat(OP_DATA, 8'hFF, 1'b0, '0);
        end
        quiet = 1'b0;
        send_beat(OP_DATA, 8'h12, 1'b1, '0);
        send_beat(OP_READ, 8'h00, 1'b0, ADDR_W'(5));
        send_beat(OP_READ, 8'h00, 1'b0, '1);
        send_beat(OP_CLEAR, 8'h00, 1'b0, '0);

        // Long receiver hold-off while the sender keeps offering.
        write_word_size(6'd2);
        hold_cycles = 400;
        random_items(30);
        foreach (sizes[i]) begin
            write_word_size(sizes[i]);
            quiet = (i == 3);
            random_items(20);
        end
        quiet = 1'b0;

        drain();
        if (tally_sb.errors == 0 && tally_sb.owed_results.size() == 0) begin
            $display("word_frequency_hash_counter_top: match");
        end else begin
            $display("word_frequency_hash_counter_top: mismatch");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/wfhc_pkg.sv
src/wfhc_if.sv
src/wfhc_ram.sv
src/word_frequency_hash_counter_top.sv
verif/word_frequency_hash_counter_top_tb.sv
